// File: rtl/mtlw_pkg.sv
// Shared types and constants for the median-of-ten load cell weigher.
package mtlw_pkg;

   // configuration register map
   localparam int TARE_BITS = 24;
   localparam int CPG_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CPG_BITS-1:0] CPG_RESET = 32'd256;

   typedef enum logic {
      CSR_TARE_OFFSET     = 1'b0,
      CSR_COUNTS_PER_GRAM = 1'b1
   } csr_index_type;

   // 2 * 2560 = 4096 + 1024: doubled tenths-of-gram scale as two shifts
   localparam int SCALE_SHIFT_HI = 12;
   localparam int SCALE_SHIFT_LO = 10;
   localparam int SCALE_GROWTH = 14;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/mtlw_sort_cell.sv
// One cell of the insertion sorting chain: holds one sorted sample and its valid bit.
module mtlw_sort_cell #(
   parameter int W = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                flush,
   input  logic                insert,
   input  logic signed [W-1:0] new_value,
   input  logic                left_valid,
   input  logic signed [W-1:0] left_value,
   output logic                valid,
   output logic signed [W-1:0] value
);

   logic                valid_ff, valid_in;
   logic signed [W-1:0] value_ff, value_in;
   logic                cur_valid;
   logic                here_below;
   logic                left_below;

   // a flushed chain looks empty to the beat arriving in the same cycle
   assign cur_valid  = valid_ff & ~flush;
   assign here_below = !cur_valid || (new_value < value_ff);
   assign left_below = !left_valid || (new_value < left_value);

   always_comb begin
      valid_in = cur_valid;
      value_in = value_ff;
      if (insert) begin
         valid_in = cur_valid | left_valid;
         if (here_below) begin
            // shift right if the new sample lands further left, else take it
            value_in = left_below ? left_value : new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = cur_valid;
   assign value = value_ff;

endmodule

// File: rtl/mtlw_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module mtlw_divider import mtlw_pkg::*; #(
   parameter int N_W = 39,
   parameter int D_W = 33
) (
   input  logic           clock,
   input  logic           reset,
   input  div_ctrl_type   ctrl,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output div_stat_type   stat,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(N_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? D_W'(trial - {1'b0, den_ff}) : trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// File: rtl/median_of_ten_load_cell_weigher.sv
// Median-of-group load cell weigher: sorting cell chain, tare/scale stage and divider.
// Each raw sample beat is inserted into a chain of GROUP_SIZE sorting cells. The beat
// that completes a group is followed by a scaling pass run by the bit-serial divider,
// which yields one quotient bit per cycle; the first samples of the next group are taken
// during that pass, but its last sample is held off until the engine is free and the
// previous result beat has been taken. The result is round(diff * 2560 / counts_per_gram)
// in tenths of a gram, rounded half away from zero and clipped to 32-bit signed with
// rsp_saturated set. A counts_per_gram of zero acts as one. Registers: tare_offset at
// byte 0, counts_per_gram at byte 4; write them only while no group is in flight.
module median_of_ten_load_cell_weigher import mtlw_pkg::*; #(
   parameter int GROUP_SIZE  = 10,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_weight_tenths,
   output logic                          rsp_saturated,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   localparam int MED    = GROUP_SIZE / 2;
   localparam int CNT_W  = $clog2(GROUP_SIZE);
   localparam int DIFF_W = ((SAMPLE_BITS > TARE_BITS) ? SAMPLE_BITS : TARE_BITS) + 1;
   localparam int N_W    = DIFF_W + SCALE_GROWTH;
   localparam int D_W    = CPG_BITS + 1;
   localparam logic [N_W-1:0] POS_MAX = N_W'(64'h7FFF_FFFF);
   localparam logic [N_W-1:0] NEG_MAX = N_W'(64'h8000_0000);
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCALE  = 3'b010,
      S_DIVIDE = 3'b100
   } state_type;

   // configuration
   logic signed [TARE_BITS-1:0] tare_ff, tare_in;
   logic [CPG_BITS-1:0]         cpg_ff, cpg_in;
   logic                        csr_write;

   // sample side
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        group_done_ff, group_done_in;
   logic                        req_accept;
   logic [GROUP_SIZE-1:0]       cell_valid;
   logic signed [SAMPLE_BITS-1:0] cell_value [GROUP_SIZE];

   // scaling engine
   state_type                   state_ff, state_in;
   logic                        neg_ff, neg_in;
   logic [DIFF_W-1:0]           mag_ff, mag_in;
   logic [CPG_BITS-1:0]         den_ff, den_in;
   logic signed [DIFF_W-1:0]    diff;
   div_ctrl_type                div_ctrl;
   div_stat_type                div_stat;
   logic [N_W-1:0]              div_num;
   logic [N_W-1:0]              quotient;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]          weight_ff, weight_in;
   logic                        sat_ff, sat_in;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      tare_in = tare_ff;
      cpg_in  = cpg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(paddr[2]))
            CSR_TARE_OFFSET:     tare_in = pwdata[TARE_BITS-1:0];
            CSR_COUNTS_PER_GRAM: cpg_in  = pwdata[CPG_BITS-1:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(paddr[2]))
         CSR_TARE_OFFSET:     prdata = CSR_DATA_BITS'(tare_ff);
         CSR_COUNTS_PER_GRAM: prdata = CSR_DATA_BITS'(cpg_ff);
         default:             prdata = '0;
      endcase
   end

   // ---------------- sample side ----------------
   // hold the group's last beat until the engine and result register are free
   assign req_stall  = (count_ff == CNT_W'(GROUP_SIZE - 1)) &&
                       ((state_ff != S_IDLE) || rsp_valid_ff || group_done_ff);
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      count_in      = count_ff;
      group_done_in = 1'b0;
      if (req_accept) begin
         if (count_ff == CNT_W'(GROUP_SIZE - 1)) begin
            count_in      = '0;
            group_done_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
      logic                          left_valid;
      logic signed [SAMPLE_BITS-1:0] left_value;
      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
         assign left_value = MOST_NEG;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_value = cell_value[i-1];
      end
      mtlw_sort_cell #(
         .W(SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .flush      (group_done_ff),
         .insert     (req_accept),
         .new_value  (req_raw_sample),
         .left_valid (left_valid),
         .left_value (left_value),
         .valid      (cell_valid[i]),
         .value      (cell_value[i])
      );
   end

   // ---------------- scaling engine ----------------
   assign diff    = DIFF_W'(cell_value[MED]) - DIFF_W'(tare_ff);
   assign div_num = (N_W'(mag_ff) << SCALE_SHIFT_HI) + (N_W'(mag_ff) << SCALE_SHIFT_LO) +
                    N_W'(den_ff);

   always_comb begin
      state_in       = state_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      den_in         = den_ff;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (group_done_ff) begin
               neg_in   = diff[DIFF_W-1];
               mag_in   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
               den_in   = (cpg_ff == '0) ? CPG_BITS'(1) : cpg_ff;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            div_ctrl.start = 1'b1;
            state_in       = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   mtlw_divider #(
      .N_W(N_W),
      .D_W(D_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .num      (div_num),
      .den      ({den_ff, 1'b0}),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      weight_in    = weight_ff;
      sat_in       = sat_ff;
      if (div_stat.done && state_ff == S_DIVIDE) begin
         rsp_valid_in = 1'b1;
         if (neg_ff) begin
            sat_in    = quotient > NEG_MAX;
            weight_in = sat_in ? 32'sh8000_0000 : 32'(32'd0 - quotient[31:0]);
         end else begin
            sat_in    = quotient > POS_MAX;
            weight_in = sat_in ? 32'sh7FFF_FFFF : 32'(quotient[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff       <= '0;
         cpg_ff        <= CPG_RESET;
         count_ff      <= '0;
         group_done_ff <= 1'b0;
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tare_ff       <= tare_in;
         cpg_ff        <= cpg_in;
         count_ff      <= count_in;
         group_done_ff <= group_done_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      den_ff    <= den_in;
      weight_ff <= weight_in;
      sat_ff    <= sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_weight_tenths = weight_ff;
   assign rsp_saturated     = sat_ff;

   // ---------------- assertions ----------------
   a_fill_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("sorting chain fill does not match sample count");

   a_engine_free_on_group: assert property (@(posedge clock) disable iff (reset)
      group_done_ff |-> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("group completed while engine or result busy");

   a_result_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DIVIDE) && $past(div_stat.done))
      else $error("result raised without a finished division");

   a_done_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside the divide state");

   a_saturated_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
         (weight_ff == 32'sh7FFF_FFFF) || (weight_ff == 32'sh8000_0000))
      else $error("saturated flag with unclipped weight");

endmodule
